// ===== design/dlq_pkg.sv =====
// ----------------------------------------------------------------------------
// dlq_pkg: shared types and constants of the linear array deque
// Holds the operation and status codes, field widths, the register map
// and the command and status structs passed between controller and datapath.
// ----------------------------------------------------------------------------
package dlq_pkg;

    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int CAP_W    = 5;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd5;

    // Register index taken from paddr[APB_AW-1:2].
    localparam logic [APB_AW-3:0] REG_CAPACITY = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Command from the controller: execute the request on the input channel.
    typedef struct packed {
        logic exec;
    } t_ctrl_cmd;

    // Status of the datapath index registers.
    typedef struct packed {
        logic empty;
        logic idx_zero;
    } t_dp_status;

endpackage

// ===== design/dlq_req_if.sv =====
// ----------------------------------------------------------------------------
// dlq_req_if: request channel of the linear array deque
// Valid/ready channel carrying one deque operation and its push value.
// ----------------------------------------------------------------------------
interface dlq_req_if;
    import dlq_pkg::*;

    logic                    valid;
    logic                    ready;
    t_op                     operation;
    logic signed [VAL_W-1:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);

endinterface

// ===== design/dlq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dlq_rsp_if: response channel of the linear array deque
// Valid/ready channel carrying the popped value and the operation status.
// ----------------------------------------------------------------------------
interface dlq_rsp_if;
    import dlq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] pop_value;
    t_status                 status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink   (input valid, input pop_value, input status, output ready);

endinterface

// ===== design/linear_array_deque.sv =====
// ----------------------------------------------------------------------------
// linear_array_deque: double-ended queue in a fixed, non-circular array
// Pushes and pops at either end, with overflow and underflow reporting and
// an APB register for the usable capacity.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Beat contents
//  --------  ---------  ----------------------  -------------------------------
//  i_req     in         valid / ready           operation, push_value
//  o_rsp     out        valid / ready           pop_value, status
//  APB       in         psel, penable, pready   capacity at byte address 0
//
// Each request produces one response beat in the cycle after it is accepted;
// the pop data comes straight from the registered read port of the slot
// memory. A new request is taken in the cycle the previous response is
// taken, so one request per cycle is sustained while o_rsp.ready stays high.
// When o_rsp stalls, the response is held and i_req.ready drops until it is
// taken. Synchronous active-low reset empties the deque and sets capacity to
// 5; the slot memory itself is not cleared.
//
module linear_array_deque #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dlq_req_if.sink                       i_req,
    dlq_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dlq_pkg::APB_AW-1:0]    paddr,
    input  logic [dlq_pkg::APB_DW-1:0]    pwdata,
    output logic [dlq_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import dlq_pkg::*;

    logic [CAP_W-1:0]    r_capacity;
    logic [CAP_W-1:0]    n_capacity;
    logic [APB_AW-3:0]   reg_idx;
    logic                cfg_write;
    t_ctrl_cmd           cmd;
    t_dp_status          dp_stat;

    // The configuration port never waits. Registers sit on 32-bit words, so
    // the word index is the byte address without its two low bits.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_capacity = r_capacity;
        if (cfg_write && (reg_idx == REG_CAPACITY)) begin
            n_capacity = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    assign prdata = (reg_idx == REG_CAPACITY) ? APB_DW'(r_capacity) : '0;

    // The controller owns the handshakes; the datapath executes a request in
    // the cycle the controller accepts it and holds the response registers.
    dlq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    dlq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_req.operation),
        .i_push_value (i_req.push_value),
        .i_capacity   (r_capacity),
        .o_pop_value  (o_rsp.pop_value),
        .o_status     (o_rsp.status),
        .o_dp_stat    (dp_stat)
    );

    // A failed operation never carries data.
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.pop_value == '0))
        else $error("failed operation returned nonzero pop_value");

    // An empty deque always has both indices back at slot 0.
    a_empty_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_stat.empty |-> dp_stat.idx_zero)
        else $error("empty deque with indices away from slot 0");

    // Every accepted request is answered in the following cycle.
    a_req_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> o_rsp.valid)
        else $error("accepted request produced no response beat");

    // Reset leaves no response pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("response valid right after reset");

endmodule

// ===== design/dlq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlq_ctrl: handshake controller of the linear array deque
// Tracks whether a response beat is held and issues the execute command.
// ----------------------------------------------------------------------------
module dlq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dlq_pkg::t_ctrl_cmd o_cmd
);
    import dlq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // A new request may enter whenever the response register is free or is
    // being emptied in this same cycle.
    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign o_out_valid = (r_state == S_RESP);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd.exec  = accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (accept) begin
                    n_state = S_RESP;
                end else if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/dlq_dp.sv =====
// ----------------------------------------------------------------------------
// dlq_dp: datapath of the linear array deque
// Slot memory, head and tail indices, empty flag and the response registers.
// ----------------------------------------------------------------------------
module dlq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dlq_pkg::t_ctrl_cmd               i_cmd,
    input  dlq_pkg::t_op                     i_op,
    input  logic signed [dlq_pkg::VAL_W-1:0] i_push_value,
    input  logic [dlq_pkg::CAP_W-1:0]        i_capacity,
    output logic signed [dlq_pkg::VAL_W-1:0] o_pop_value,
    output dlq_pkg::t_status                 o_status,
    output dlq_pkg::t_dp_status              o_dp_stat
);
    import dlq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic signed [VAL_W-1:0] mem [DEPTH];

    logic [AW-1:0]           r_head, n_head;
    logic [AW-1:0]           r_tail, n_tail;
    logic                    r_empty, n_empty;
    logic                    r_pop_ok, n_pop_ok;
    t_status                 r_status, n_status;
    logic signed [VAL_W-1:0] r_rd_data;

    logic [CW-1:0]           cap_ext;
    logic [CW-1:0]           usable;
    logic [CW-1:0]           tail_next_ext;
    logic                    is_push;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;

    // Usable slots are the configured capacity clipped to the array depth.
    assign cap_ext       = CW'(i_capacity);
    assign usable        = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    assign tail_next_ext = CW'(r_tail) + CW'(1);
    assign is_push       = i_op inside {OP_PUSH_REAR, OP_PUSH_FRONT};

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = ST_OK;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_tail;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        if (is_push) begin
            if (usable == '0) begin
                n_status = ST_OVERFLOW;
            end else if (r_empty) begin
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b0;
                wr_en   = 1'b1;
                wr_addr = '0;
            end else if (i_op == OP_PUSH_REAR) begin
                if (tail_next_ext >= usable) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_tail  = r_tail + AW'(1);
                    wr_en   = 1'b1;
                    wr_addr = r_tail + AW'(1);
                end
            end else begin
                if (r_head == '0) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_head  = r_head - AW'(1);
                    wr_en   = 1'b1;
                    wr_addr = r_head - AW'(1);
                end
            end
        end else begin
            if (r_empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                n_pop_ok = 1'b1;
                rd_en    = 1'b1;
                rd_addr  = (i_op == OP_POP_FRONT) ? r_head : r_tail;
                if (r_head == r_tail) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else if (i_op == OP_POP_FRONT) begin
                    n_head = r_head + AW'(1);
                end else begin
                    n_tail = r_tail - AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_pop_ok <= 1'b0;
            r_status <= ST_OK;
        end else if (i_cmd.exec) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_empty  <= n_empty;
            r_pop_ok <= n_pop_ok;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_pop_value        = r_pop_ok ? r_rd_data : '0;
    assign o_status           = r_status;
    assign o_dp_stat.empty    = r_empty;
    assign o_dp_stat.idx_zero = (r_head == '0) && (r_tail == '0);

endmodule
